// File: hdl/stereo_peak_meter_decay_top_macros.svh
// assertion macros for the stereo peak meter block
// included by the files that check their own logic; no other dependencies
`ifndef STEREO_PEAK_METER_DECAY_TOP_MACROS_SVH
`define STEREO_PEAK_METER_DECAY_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SPM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SPM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/spm_pkg.sv
// shared constants, types and helpers of the stereo peak meter
// no dependencies
package spm_pkg;

   localparam int SLOTS       = 64;
   localparam int SAMPLE_BITS = 16;
   localparam int FUNC_W      = 3;
   localparam int SLOT_W      = 6;
   localparam int LEVEL_W     = 10;
   localparam int DISP_W      = 18;
   localparam int DECAY_W     = 16;
   localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = LEVEL_W'(1000);
   localparam logic [DECAY_W-1:0] DECAY_RESET  = DECAY_W'(55706);
   localparam logic [SLOT_W:0]    SLOT_LIMIT   = (SLOT_W+1)'(SLOTS);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SAMPLE = 3'd0,
      FUNC_TICK   = 3'd1,
      FUNC_READ   = 3'd2,
      FUNC_OPEN   = 3'd3,
      FUNC_CLOSE  = 3'd4
   } spm_func_type;

   // item after the input register, sample levels already scaled
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [SLOT_W-1:0]  slot;
      logic [LEVEL_W-1:0] lvl_left;
      logic [LEVEL_W-1:0] lvl_right;
   } spm_stage_type;

   // one slot's stored meter state
   typedef struct packed {
      logic [LEVEL_W-1:0] peak_left;
      logic [LEVEL_W-1:0] peak_right;
      logic [DISP_W-1:0]  disp_left;
      logic [DISP_W-1:0]  disp_right;
   } spm_entry_type;

   localparam int ENTRY_W = $bits(spm_entry_type);

   // update decision handed back to the top level
   typedef struct packed {
      logic               write;
      logic               set_live;
      logic               clear_live;
      logic               result;
      spm_entry_type      entry;
      logic [LEVEL_W-1:0] level_left;
      logic [LEVEL_W-1:0] level_right;
   } spm_upd_type;

   function automatic logic slot_in_range(logic [SLOT_W-1:0] s);
      return {1'b0, s} < SLOT_LIMIT;
   endfunction

endpackage

// File: hdl/spm_if.sv
// channel interfaces of the stereo peak meter: request, response, csr write
// depends on spm_pkg
interface spm_req_if;
   import spm_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [FUNC_W-1:0]             func;
   logic [SLOT_W-1:0]             slot;
   logic signed [SAMPLE_BITS-1:0] sample_left;
   logic signed [SAMPLE_BITS-1:0] sample_right;
   modport source(output valid, func, slot, sample_left, sample_right, input ready);
   modport sink(input valid, func, slot, sample_left, sample_right, output ready);
endinterface

interface spm_rsp_if;
   import spm_pkg::*;
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  slot_out;
   logic [LEVEL_W-1:0] level_left;
   logic [LEVEL_W-1:0] level_right;
   modport source(output valid, slot_out, level_left, level_right, input ready);
   modport sink(input valid, slot_out, level_left, level_right, output ready);
endinterface

interface spm_csr_if;
   import spm_pkg::*;
   logic               valid;
   logic               ready;
   logic [DECAY_W-1:0] data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

// File: hdl/spm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module spm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: hdl/spm_scale.sv
// scales one signed sample to a 0..1000 meter level, rounded and saturated
// depends on spm_pkg
module spm_scale (
   input  logic signed [spm_pkg::SAMPLE_BITS-1:0] sample,
   output logic [spm_pkg::LEVEL_W-1:0]            level
);
   import spm_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + LEVEL_W;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (SAMPLE_BITS - 2);

   logic [SAMPLE_BITS-1:0] mag;
   logic [PROD_W-1:0]      prod;
   logic [PROD_W-1:0]      rounded;
   logic [LEVEL_W:0]       lvl;

   // two's complement magnitude, most negative value stays as full scale
   assign mag     = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
   assign prod    = PROD_W'(mag) * PROD_W'(1000);
   assign rounded = prod + HALF;
   assign lvl     = rounded[SAMPLE_BITS-1 +: LEVEL_W+1];
   assign level   = (lvl > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : lvl[LEVEL_W-1:0];
endmodule

// File: hdl/spm_update.sv
// per-item update of one meter slot: peak hold, tick attack/decay, read, open, close
// depends on spm_pkg
module spm_update (
   input  spm_pkg::spm_stage_type          stage,
   input  spm_pkg::spm_entry_type          entry,
   input  logic                            live,
   input  logic [spm_pkg::DECAY_W-1:0]     decay,
   output spm_pkg::spm_upd_type            upd
);
   import spm_pkg::*;

   localparam int PROD_W = DISP_W + DECAY_W;

   logic                slot_ok;
   logic [DISP_W-1:0]   att_left;
   logic [DISP_W-1:0]   att_right;
   logic [PROD_W-1:0]   prod_left;
   logic [PROD_W-1:0]   prod_right;
   logic [DISP_W-1:0]   tick_left;
   logic [DISP_W-1:0]   tick_right;
   logic [DISP_W:0]     rnd_left;
   logic [DISP_W:0]     rnd_right;
   logic [LEVEL_W:0]    lvl_left;
   logic [LEVEL_W:0]    lvl_right;

   assign slot_ok = slot_in_range(stage.slot);

   // fast attack to the held peak, otherwise exponential decay
   assign att_left   = {entry.peak_left, 8'd0};
   assign att_right  = {entry.peak_right, 8'd0};
   assign prod_left  = PROD_W'(entry.disp_left) * PROD_W'(decay);
   assign prod_right = PROD_W'(entry.disp_right) * PROD_W'(decay);
   assign tick_left  = (att_left >= entry.disp_left) ? att_left : prod_left[DECAY_W +: DISP_W];
   assign tick_right = (att_right >= entry.disp_right) ? att_right
                                                       : prod_right[DECAY_W +: DISP_W];

   // round half up to whole units
   assign rnd_left  = {1'b0, entry.disp_left} + (DISP_W+1)'(128);
   assign rnd_right = {1'b0, entry.disp_right} + (DISP_W+1)'(128);
   assign lvl_left  = rnd_left[8 +: LEVEL_W+1];
   assign lvl_right = rnd_right[8 +: LEVEL_W+1];

   always_comb begin
      upd             = '0;
      upd.entry       = entry;
      upd.level_left  = '0;
      upd.level_right = '0;
      case (spm_func_type'(stage.func))
         FUNC_SAMPLE: begin
            upd.write = live;
            if (stage.lvl_left > entry.peak_left) begin
               upd.entry.peak_left = stage.lvl_left;
            end
            if (stage.lvl_right > entry.peak_right) begin
               upd.entry.peak_right = stage.lvl_right;
            end
         end
         FUNC_TICK: begin
            upd.write             = live;
            upd.entry.peak_left   = '0;
            upd.entry.peak_right  = '0;
            upd.entry.disp_left   = tick_left;
            upd.entry.disp_right  = tick_right;
         end
         FUNC_READ: begin
            upd.result = 1'b1;
            if (live) begin
               upd.level_left  = (lvl_left > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
                                                                : lvl_left[LEVEL_W-1:0];
               upd.level_right = (lvl_right > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
                                                                 : lvl_right[LEVEL_W-1:0];
            end
         end
         FUNC_OPEN: begin
            upd.write    = slot_ok;
            upd.set_live = slot_ok;
            upd.entry    = '0;
         end
         FUNC_CLOSE: begin
            upd.write      = slot_ok;
            upd.clear_live = slot_ok;
            upd.entry      = '0;
         end
         default: begin
            upd.write = 1'b0;
         end
      endcase
   end
endmodule

// File: hdl/stereo_peak_meter_decay_top.sv
// stereo peak meter table: top level with input stage, slot ram and response register
// a read item's levels pass the input stage and then the response register on the way to rsp
// throughput: one item per cycle; only a read waiting on a full response register stalls
// reset: synchronous, clears every slot to closed and the decay factor to 55706
// no clearing pass: slot state in ram is zeroed by the open item itself
// depends on spm_pkg, spm_if, spm_ram, spm_scale, spm_update and the macros header
`include "stereo_peak_meter_decay_top_macros.svh"

module stereo_peak_meter_decay_top (
   input  logic       clock,
   input  logic       reset,
   spm_req_if.sink    req_ch,
   spm_rsp_if.source  rsp_ch,
   spm_csr_if.sink    csr_ch
);
   import spm_pkg::*;

   // decay factor register; the user must write it only while idle, the block does not enforce this
   logic [DECAY_W-1:0] decay_ff, decay_in;

   // input stage: item with sample levels already scaled
   logic                 s1_valid_ff, s1_valid_in;
   spm_stage_type        s1_ff, s1_in;
   logic [LEVEL_W-1:0]   scale_left;
   logic [LEVEL_W-1:0]   scale_right;

   // per-slot open flags
   logic [SLOTS-1:0]     live_ff, live_in;
   logic [SLOT_IDX_W-1:0] s1_idx;
   logic                 s1_live;

   // slot ram and bypass of the last write
   spm_entry_type        ram_rdata;
   spm_entry_type        cur_entry;
   logic                 fwd_valid_ff, fwd_valid_in;
   logic [SLOT_W-1:0]    fwd_slot_ff, fwd_slot_in;
   spm_entry_type        fwd_data_ff, fwd_data_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [LEVEL_W-1:0]   rsp_left_ff, rsp_left_in;
   logic [LEVEL_W-1:0]   rsp_right_ff, rsp_right_in;

   // handshake
   logic                 req_xfer;
   logic                 out_free;
   logic                 s1_commit;
   logic                 s1_advance;
   logic                 ram_we;
   spm_upd_type          upd;

   // scale the samples on the way into the input stage
   spm_scale u_scale_left (
      .sample (req_ch.sample_left),
      .level  (scale_left)
   );

   spm_scale u_scale_right (
      .sample (req_ch.sample_right),
      .level  (scale_right)
   );

   // the response register frees up when empty or being taken
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;
   // only a read needs room at the output
   assign s1_commit  = s1_valid_ff
                       && ((spm_func_type'(s1_ff.func) != FUNC_READ) || out_free);
   assign s1_advance = !s1_valid_ff || s1_commit;
   assign req_xfer   = req_ch.valid && s1_advance;

   assign req_ch.ready = s1_advance;
   assign csr_ch.ready = 1'b1;

   // slot ram: read at req transfer, written when the input stage commits
   assign ram_we = s1_commit && upd.write;

   spm_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_idx),
      .wdata (upd.entry),
      .re    (req_xfer),
      .raddr (req_ch.slot[SLOT_IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   // the ram read of the next item may miss the write of the item just ahead
   assign s1_idx    = s1_ff.slot[SLOT_IDX_W-1:0];
   assign cur_entry = (fwd_valid_ff && (fwd_slot_ff == s1_ff.slot)) ? fwd_data_ff : ram_rdata;
   assign s1_live   = slot_in_range(s1_ff.slot) && live_ff[s1_idx];

   spm_update u_update (
      .stage (s1_ff),
      .entry (cur_entry),
      .live  (s1_live),
      .decay (decay_ff),
      .upd   (upd)
   );

   always_comb begin
      decay_in = decay_ff;
      if (csr_ch.valid) begin
         decay_in = csr_ch.data;
      end

      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (s1_advance) begin
         s1_valid_in     = req_ch.valid;
         s1_in.func      = req_ch.func;
         s1_in.slot      = req_ch.slot;
         s1_in.lvl_left  = scale_left;
         s1_in.lvl_right = scale_right;
      end

      live_in = live_ff;
      if (s1_commit && upd.set_live) begin
         live_in[s1_idx] = 1'b1;
      end
      if (s1_commit && upd.clear_live) begin
         live_in[s1_idx] = 1'b0;
      end

      fwd_valid_in = fwd_valid_ff;
      fwd_slot_in  = fwd_slot_ff;
      fwd_data_in  = fwd_data_ff;
      if (ram_we) begin
         fwd_valid_in = 1'b1;
         fwd_slot_in  = s1_ff.slot;
         fwd_data_in  = upd.entry;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_slot_in  = rsp_slot_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      if (s1_commit && upd.result) begin
         rsp_valid_in = 1'b1;
         rsp_slot_in  = s1_ff.slot;
         rsp_left_in  = upd.level_left;
         rsp_right_in = upd.level_right;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff     <= DECAY_RESET;
         s1_valid_ff  <= 1'b0;
         live_ff      <= '0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         decay_ff     <= decay_in;
         s1_valid_ff  <= s1_valid_in;
         live_ff      <= live_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      fwd_slot_ff  <= fwd_slot_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.slot_out    = rsp_slot_ff;
   assign rsp_ch.level_left  = rsp_left_ff;
   assign rsp_ch.level_right = rsp_right_ff;

   // a committed read always lands in the response register
   `SPM_ASSERT_NEXT(a_read_to_rsp, clock, reset, s1_commit && upd.result, rsp_ch.valid, "read result lost")
   // a stalled item keeps its place in the input stage
   `SPM_ASSERT_NEXT(a_stage_hold, clock, reset, s1_valid_ff && !s1_commit, s1_valid_ff && $stable(s1_ff), "stalled item changed")
   // a request transfer always fills the input stage
   `SPM_ASSERT_NEXT(a_req_fill, clock, reset, req_xfer, s1_valid_ff, "accepted item dropped")
   // reported levels stay within the meter scale
   `SPM_ASSERT_IMPL(a_level_range, clock, reset, rsp_ch.valid, (rsp_ch.level_left <= LEVEL_MAX) && (rsp_ch.level_right <= LEVEL_MAX), "level out of range")
endmodule

// File: bench/tb.sv
// self-checking bench for stereo_peak_meter_decay_top: directed table, random phases, then a long receiver hold
// depends on spm_pkg, spm_if and the top level from the rtl; a local meter model predicts every read but the typed rows
`timescale 1ns / 1ps

module tb;
   import spm_pkg::*;

   // func codes the block ignores
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;
   localparam int POOL_SIZE   = 8;
   localparam int PHASE_ITEMS = 95;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [LEVEL_W-1:0] left;
      logic [LEVEL_W-1:0] right;
   } meter_reading_type;

   // one directed item; typed rows carry their levels, the rest use the local model
   typedef struct packed {
      logic [FUNC_W-1:0]             func;
      logic [SLOT_W-1:0]             slot;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic                          typed;
      logic [LEVEL_W-1:0]            want_left;
      logic [LEVEL_W-1:0]            want_right;
   } meter_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spm_req_if req_ch ();
   spm_rsp_if rsp_ch ();
   spm_csr_if csr_ch ();

   stereo_peak_meter_decay_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // local copy of the meter table
   logic [LEVEL_W-1:0] meter_peak_l [SLOTS];
   logic [LEVEL_W-1:0] meter_peak_r [SLOTS];
   logic [DISP_W-1:0]  meter_disp_l [SLOTS];
   logic [DISP_W-1:0]  meter_disp_r [SLOTS];
   logic               meter_open   [SLOTS];
   logic [DECAY_W-1:0] decay_now;

   meter_reading_type levels_due [$];
   int mismatches   = 0;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int hold_request = 0;

   meter_row_type directed_rows [26] = '{
      '{FUNC_READ,   6'd0,  16'h0000, 16'h0000, 1'b1, 10'd0,    10'd0},    // closed after reset
      '{FUNC_SAMPLE, 6'd0,  16'h8000, 16'h7fff, 1'b0, 10'd0,    10'd0},    // closed, ignored
      '{FUNC_TICK,   6'd0,  16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},    // closed, ignored
      '{FUNC_OPEN,   6'd0,  16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},
      '{FUNC_READ,   6'd0,  16'h0000, 16'h0000, 1'b1, 10'd0,    10'd0},    // fresh slot
      '{FUNC_SAMPLE, 6'd0,  16'h8000, 16'h7fff, 1'b0, 10'd0,    10'd0},    // both extremes
      '{FUNC_TICK,   6'd0,  16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},    // attack to full
      '{FUNC_READ,   6'd0,  16'h0000, 16'h0000, 1'b1, 10'd1000, 10'd1000},
      '{FUNC_TICK,   6'd0,  16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},    // decay, no peak
      '{FUNC_READ,   6'd0,  16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},
      '{FUNC_SAMPLE, 6'd0,  16'h0010, 16'hffef, 1'b0, 10'd0,    10'd0},    // rounding edge
      '{FUNC_SAMPLE, 6'd0,  16'h0000, 16'hffff, 1'b0, 10'd0,    10'd0},
      '{FUNC_TICK,   6'd0,  16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},    // small peak decays
      '{FUNC_READ,   6'd0,  16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},
      '{FUNC_OPEN,   6'd63, 16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},
      '{FUNC_SAMPLE, 6'd63, 16'h4000, 16'hc000, 1'b0, 10'd0,    10'd0},    // half scale
      '{FUNC_SAMPLE, 6'd63, 16'h0064, 16'h7d00, 1'b0, 10'd0,    10'd0},    // max-hold
      '{FUNC_TICK,   6'd63, 16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},
      '{FUNC_READ,   6'd63, 16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},
      '{FUNC_OPEN,   6'd0,  16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},    // reopen clears
      '{FUNC_READ,   6'd0,  16'h0000, 16'h0000, 1'b1, 10'd0,    10'd0},
      '{FUNC_CLOSE,  6'd63, 16'h0000, 16'h0000, 1'b0, 10'd0,    10'd0},
      '{FUNC_READ,   6'd63, 16'h0000, 16'h0000, 1'b1, 10'd0,    10'd0},    // closed again
      '{FUNC_SPARE_FIRST, 6'd1, 16'h1234, 16'h8000, 1'b0, 10'd0, 10'd0},  // unused code
      '{FUNC_SPARE_LAST,  6'd2, 16'h7fff, 16'h0001, 1'b0, 10'd0, 10'd0},  // unused code
      '{FUNC_READ,   6'd1,  16'h0000, 16'h0000, 1'b1, 10'd0,    10'd0}     // never opened
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // |s| scaled to 0..1000, rounded half up, saturated
   function automatic logic [LEVEL_W-1:0] sample_to_level(logic signed [SAMPLE_BITS-1:0] s);
      int mag;
      int lvl;
      mag = s;
      if (mag < 0) mag = -mag;
      lvl = (mag * 1000 + (1 << (SAMPLE_BITS - 2))) / (1 << (SAMPLE_BITS - 1));
      return (lvl > 1000) ? LEVEL_MAX : LEVEL_W'(lvl);
   endfunction

   // fast attack if the peak reaches the display, else truncated decay
   function automatic logic [DISP_W-1:0] tick_display(logic [DISP_W-1:0] disp,
                                                      logic [LEVEL_W-1:0] peak);
      logic [DISP_W-1:0] attack;
      longint unsigned   prod;
      attack = {peak, 8'd0};
      if (attack >= disp) return attack;
      prod = longint'(disp) * longint'(decay_now);
      return DISP_W'(prod >> 16);
   endfunction

   function automatic logic [LEVEL_W-1:0] display_to_level(logic [DISP_W-1:0] disp);
      int lvl;
      lvl = (int'(disp) + 128) >> 8;
      return (lvl > 1000) ? LEVEL_MAX : LEVEL_W'(lvl);
   endfunction

   function automatic void clear_meter(logic [SLOT_W-1:0] slot);
      meter_peak_l[slot] = '0;
      meter_peak_r[slot] = '0;
      meter_disp_l[slot] = '0;
      meter_disp_r[slot] = '0;
   endfunction

   // advance the local table by one accepted item
   function automatic void meter_update(input logic [FUNC_W-1:0] func,
                                        input logic [SLOT_W-1:0] slot,
                                        input logic signed [SAMPLE_BITS-1:0] left,
                                        input logic signed [SAMPLE_BITS-1:0] right,
                                        output bit makes_reading,
                                        output meter_reading_type reading);
      logic               live;
      logic [LEVEL_W-1:0] lvl_l;
      logic [LEVEL_W-1:0] lvl_r;
      live = meter_open[slot];
      makes_reading = 1'b0;
      reading = '{slot, '0, '0};
      case (func)
         FUNC_SAMPLE: begin
            if (live) begin
               lvl_l = sample_to_level(left);
               lvl_r = sample_to_level(right);
               if (lvl_l > meter_peak_l[slot]) meter_peak_l[slot] = lvl_l;
               if (lvl_r > meter_peak_r[slot]) meter_peak_r[slot] = lvl_r;
            end
         end
         FUNC_TICK: begin
            if (live) begin
               meter_disp_l[slot] = tick_display(meter_disp_l[slot], meter_peak_l[slot]);
               meter_disp_r[slot] = tick_display(meter_disp_r[slot], meter_peak_r[slot]);
               meter_peak_l[slot] = '0;
               meter_peak_r[slot] = '0;
            end
         end
         FUNC_READ: begin
            makes_reading = 1'b1;
            if (live) begin
               reading.left  = display_to_level(meter_disp_l[slot]);
               reading.right = display_to_level(meter_disp_r[slot]);
            end
         end
         FUNC_OPEN: begin
            clear_meter(slot);
            meter_open[slot] = 1'b1;
         end
         FUNC_CLOSE: begin
            clear_meter(slot);
            meter_open[slot] = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // offer one item, idling first at the phase's rate; returns at its transfer edge
   task automatic offer_item(input logic [FUNC_W-1:0] func, input logic [SLOT_W-1:0] slot,
                             input logic signed [SAMPLE_BITS-1:0] left,
                             input logic signed [SAMPLE_BITS-1:0] right,
                             input logic typed, input logic [LEVEL_W-1:0] want_left,
                             input logic [LEVEL_W-1:0] want_right);
      bit                makes_reading;
      meter_reading_type reading;
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= func;
      req_ch.slot         <= slot;
      req_ch.sample_left  <= left;
      req_ch.sample_right <= right;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      meter_update(func, slot, left, right, makes_reading, reading);
      if (makes_reading) begin
         if (typed) begin
            reading.left  = want_left;
            reading.right = want_right;
         end
         levels_due.push_back(reading);
      end
   endtask

   // stop offering until every read has come back, then let the pipeline empty
   task automatic drain_reads();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (levels_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_decay(input logic [DECAY_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      decay_now = value;
   endtask

   // a small working set of slots at both ends of the table
   function automatic logic [SLOT_W-1:0] pool_slot(int idx);
      return (idx < POOL_SIZE / 2) ? SLOT_W'(idx) : SLOT_W'(SLOTS - POOL_SIZE + idx);
   endfunction

   function automatic logic [SLOT_W-1:0] pick_slot();
      if ($urandom_range(0, 99) < 80) return pool_slot($urandom_range(0, POOL_SIZE - 1));
      return SLOT_W'($urandom_range(0, SLOTS - 1));
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      logic signed [SAMPLE_BITS-1:0] s;
      case ($urandom_range(0, 9))
         0:       s = 16'h8000;
         1:       s = 16'h7fff;
         2:       s = SAMPLE_BITS'($urandom_range(0, 40));
         3:       s = -SAMPLE_BITS'($urandom_range(0, 40));
         default: s = SAMPLE_BITS'($urandom);
      endcase
      return s;
   endfunction

   task automatic random_item();
      int                roll;
      logic [FUNC_W-1:0] func;
      roll = $urandom_range(0, 99);
      if (roll < 55)      func = FUNC_SAMPLE;
      else if (roll < 70) func = FUNC_TICK;
      else if (roll < 88) func = FUNC_READ;
      else if (roll < 92) func = FUNC_OPEN;
      else if (roll < 95) func = FUNC_CLOSE;
      else                func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      offer_item(func, pick_slot(), pick_sample(), pick_sample(), 1'b0, '0, '0);
   endtask

   // response side: check each transfer, drive ready with random stalls or a long hold
   always @(posedge clock) begin
      meter_reading_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (levels_due.size() == 0) begin
            $error("response transfer with no read outstanding, slot_out %0d", rsp_ch.slot_out);
            mismatches++;
         end else begin
            want = levels_due.pop_front();
            if (rsp_ch.slot_out !== want.slot) begin
               $error("slot_out: expected %0d, got %0d", want.slot, rsp_ch.slot_out);
               mismatches++;
            end
            if (rsp_ch.level_left !== want.left) begin
               $error("level_left: expected %0d, got %0d", want.left, rsp_ch.level_left);
               mismatches++;
            end
            if (rsp_ch.level_right !== want.right) begin
               $error("level_right: expected %0d, got %0d", want.right, rsp_ch.level_right);
               mismatches++;
            end
         end
      end
      if (hold_request > 0) begin
         hold_request = hold_request - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   initial begin
      logic [DECAY_W-1:0] phase_decay [4];
      int                 phase_idle  [4];
      int                 phase_stall [4];
      req_ch.valid        = 1'b0;
      req_ch.func         = '0;
      req_ch.slot         = '0;
      req_ch.sample_left  = '0;
      req_ch.sample_right = '0;
      csr_ch.valid        = 1'b0;
      csr_ch.data         = '0;
      for (int i = 0; i < SLOTS; i++) begin
         clear_meter(SLOT_W'(i));
         meter_open[i] = 1'b0;
      end
      decay_now = DECAY_RESET;
      phase_decay = '{16'hffff, 16'h0000, DECAY_W'($urandom), 16'h8000};
      phase_idle  = '{0, 57, 0, 36};
      phase_stall = '{0, 0, 57, 36};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset decay factor
      foreach (directed_rows[i])
         offer_item(directed_rows[i].func, directed_rows[i].slot, directed_rows[i].left,
                    directed_rows[i].right, directed_rows[i].typed,
                    directed_rows[i].want_left, directed_rows[i].want_right);
      drain_reads();

      // random phases, each with its own decay and idling mix
      for (int p = 0; p < 4; p++) begin
         write_decay(phase_decay[p]);
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         for (int i = 0; i < POOL_SIZE; i++)
            offer_item(FUNC_OPEN, pool_slot(i), '0, '0, 1'b0, '0, '0);
         repeat (PHASE_ITEMS) random_item();
         drain_reads();
      end

      // long receiver hold while reads keep coming, so the input backs up
      idle_pct  = 0;
      stall_pct = 0;
      hold_request = 150;
      repeat (30)
         offer_item(FUNC_READ, pick_slot(), '0, '0, 1'b0, '0, '0);
      drain_reads();

      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/spm_pkg.sv
hdl/spm_if.sv
hdl/spm_ram.sv
hdl/spm_scale.sv
hdl/spm_update.sv
hdl/stereo_peak_meter_decay_top.sv
bench/tb.sv
